// ===== sv/mwm_pkg.sv =====
package mwm_pkg;

  // Sizes of the key table, the window and the text counters.
  localparam int unsigned MAX_PATTERN = 1024;
  localparam int unsigned IDX_W       = 10;
  localparam int unsigned LEN_W       = 11;
  localparam int unsigned CNT_W       = 12;
  localparam int unsigned POS_W       = 17;
  localparam int unsigned SCORE_W     = 63;

  localparam logic [LEN_W-1:0] LEN_MAX      = LEN_W'(MAX_PATTERN);
  localparam logic [LEN_W-1:0] FOREIGN_SLOT = LEN_W'(MAX_PATTERN);
  localparam logic [POS_W-1:0] MAX_TEXT     = 17'h10000;
  localparam logic [POS_W-1:0] SINCE_LIMIT  = 17'h1FFFF;

  // Item actions.
  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_PATTERN = 2'd1,
    ACT_TEXT    = 2'd2,
    ACT_NOP     = 2'd3
  } action_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WS_RD,
    ST_WS_CHK,
    ST_SRCH,
    ST_CNT_RD,
    ST_CNT_WR,
    ST_FIN,
    ST_SQ,
    ST_ACC,
    ST_OUT
  } state_e;

  // What follows a count update.
  typedef enum logic [1:0] {
    PH_LEAVE,
    PH_PAT,
    PH_ENTER
  } phase_e;

endpackage

// ===== sv/multiset_window_match.sv =====
// Sliding-window multiset matcher.
// Input channel (in_valid_i / in_stall_o) carries action_i and value_i. Action
// clear starts a new case, pattern values build the key table, text values
// slide the window. Every input item gives exactly one result transfer on the
// output channel (out_valid_o / out_stall_i): match flag, 1-based window start,
// saturating score and the key table overflow flag.
// The configuration channel (cfg_valid_i / cfg_ready_o) writes pattern_length
// and clears the case; it is taken only while the sequencer is idle.
// A clear or ignored item goes straight to the output state. A
// pattern item scans the key table one entry a cycle through the key memory
// read port before it is offered. A text item retires the leaving value
// through its stored key index and scans once before it is offered.
// The key scan is the one shared compare unit and sets the throughput.
// A result waits in the output register while the receiver stalls; the next
// item is accepted meanwhile, but its result is held until the register frees.
// Reset sets pattern_length to 1 and empties the case; no clearing pass runs.
module multiset_window_match (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic signed [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        window_match_o,
  output logic [16:0] window_start_o,
  output logic [62:0] score_total_o,
  output logic        table_overflow_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [10:0] cfg_data_i
);

  mwm_pkg::state_e state_q, state_d;
  mwm_pkg::phase_e phase_q, phase_d;
  mwm_pkg::action_e act_q, act_d;

  logic [31:0] key_q, key_d;
  logic [mwm_pkg::LEN_W-1:0] len_q, len_d;
  logic [mwm_pkg::LEN_W-1:0] taken_q, taken_d;
  logic [mwm_pkg::LEN_W-1:0] used_q, used_d;
  logic [mwm_pkg::LEN_W-1:0] sur_q, sur_d;
  logic [mwm_pkg::LEN_W-1:0] def_q, def_d;
  logic [mwm_pkg::POS_W-1:0] since_q, since_d;
  logic [mwm_pkg::POS_W-1:0] pos_q, pos_d;
  logic [mwm_pkg::IDX_W-1:0] slot_q, slot_d;
  logic [mwm_pkg::SCORE_W-1:0] score_q, score_d;
  logic ovf_q, ovf_d;
  logic [mwm_pkg::LEN_W-1:0] scan_q, scan_d;
  logic pend_q, pend_d;
  logic [mwm_pkg::IDX_W-1:0] pend_idx_q;
  logic [mwm_pkg::IDX_W-1:0] cidx_q, cidx_d;
  logic res_match_q, res_match_d;
  logic [mwm_pkg::POS_W-1:0] res_start_q, res_start_d;
  logic [33:0] prod_q;
  logic out_valid_q, out_valid_d;
  logic out_match_q;
  logic [mwm_pkg::POS_W-1:0] out_start_q;
  logic [mwm_pkg::SCORE_W-1:0] out_score_q;
  logic out_ovf_q;
  logic out_load;

  // Memories and their ports.
  logic [31:0] key_mem [mwm_pkg::MAX_PATTERN];
  logic [mwm_pkg::CNT_W-1:0] cnt_mem [mwm_pkg::MAX_PATTERN];
  logic [mwm_pkg::LEN_W-1:0] ws_mem [mwm_pkg::MAX_PATTERN];
  logic [31:0] key_rdata_q;
  logic [mwm_pkg::CNT_W-1:0] cnt_rdata_q;
  logic [mwm_pkg::LEN_W-1:0] ws_rdata_q;
  logic key_we, cnt_we, ws_we;
  logic [mwm_pkg::IDX_W-1:0] key_waddr, cnt_waddr;
  logic [mwm_pkg::CNT_W-1:0] cnt_wdata;
  logic [mwm_pkg::LEN_W-1:0] ws_wdata;

  logic hit, is_up;
  logic [mwm_pkg::IDX_W-1:0] found_idx;
  logic found;
  logic [mwm_pkg::CNT_W-1:0] cnt_new;
  logic [mwm_pkg::POS_W-1:0] pos_inc;
  logic [63:0] acc_sum;
  logic [mwm_pkg::LEN_W-1:0] cfg_len;

  // Key store: written at allocation, read by the scan.
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_q;
    end
    key_rdata_q <= key_mem[scan_q[mwm_pkg::IDX_W-1:0]];
  end

  // Signed count per key.
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rdata_q <= cnt_mem[cidx_q];
  end

  // Key index of every value in the window, foreign marked.
  always_ff @(posedge clk_i) begin
    if (ws_we) begin
      ws_mem[slot_q] <= ws_wdata;
    end
    ws_rdata_q <= ws_mem[slot_q];
  end

  // Scan pipeline and multiplier registers.
  always_ff @(posedge clk_i) begin
    pend_idx_q <= scan_q[mwm_pkg::IDX_W-1:0];
    prod_q     <= 34'(res_start_q) * 34'(res_start_q);
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_match_q <= res_match_q;
      out_start_q <= res_start_q;
      out_score_q <= score_q;
      out_ovf_q   <= ovf_q;
    end
  end

  // Control and case state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mwm_pkg::ST_IDLE;
      phase_q     <= mwm_pkg::PH_LEAVE;
      act_q       <= mwm_pkg::ACT_NOP;
      key_q       <= '0;
      len_q       <= mwm_pkg::LEN_W'(1);
      taken_q     <= '0;
      used_q      <= '0;
      sur_q       <= '0;
      def_q       <= '0;
      since_q     <= '0;
      pos_q       <= '0;
      slot_q      <= '0;
      score_q     <= '0;
      ovf_q       <= 1'b0;
      scan_q      <= '0;
      pend_q      <= 1'b0;
      cidx_q      <= '0;
      res_match_q <= 1'b0;
      res_start_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      act_q       <= act_d;
      key_q       <= key_d;
      len_q       <= len_d;
      taken_q     <= taken_d;
      used_q      <= used_d;
      sur_q       <= sur_d;
      def_q       <= def_d;
      since_q     <= since_d;
      pos_q       <= pos_d;
      slot_q      <= slot_d;
      score_q     <= score_d;
      ovf_q       <= ovf_d;
      scan_q      <= scan_d;
      pend_q      <= pend_d;
      cidx_q      <= cidx_d;
      res_match_q <= res_match_d;
      res_start_q <= res_start_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Helper values for the sequencer.
  assign hit       = pend_q && (key_rdata_q == key_q);
  assign found     = hit;
  assign found_idx = pend_idx_q;
  assign is_up     = (phase_q != mwm_pkg::PH_ENTER);
  assign cnt_new   = is_up ? cnt_rdata_q + mwm_pkg::CNT_W'(1)
                           : cnt_rdata_q - mwm_pkg::CNT_W'(1);
  assign pos_inc   = pos_q + mwm_pkg::POS_W'(1);
  assign acc_sum   = {1'b0, score_q} + 64'(prod_q);

  always_comb begin
    if (cfg_data_i == '0) begin
      cfg_len = mwm_pkg::LEN_W'(1);
    end else if (cfg_data_i > mwm_pkg::LEN_MAX) begin
      cfg_len = mwm_pkg::LEN_MAX;
    end else begin
      cfg_len = cfg_data_i;
    end
  end

  // Sequencer: next state and datapath control.
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    act_d       = act_q;
    key_d       = key_q;
    len_d       = len_q;
    taken_d     = taken_q;
    used_d      = used_q;
    sur_d       = sur_q;
    def_d       = def_q;
    since_d     = since_q;
    pos_d       = pos_q;
    slot_d      = slot_q;
    score_d     = score_q;
    ovf_d       = ovf_q;
    scan_d      = scan_q;
    pend_d      = 1'b0;
    cidx_d      = cidx_q;
    res_match_d = res_match_q;
    res_start_d = res_start_q;
    key_we      = 1'b0;
    key_waddr   = used_q[mwm_pkg::IDX_W-1:0];
    cnt_we      = 1'b0;
    cnt_waddr   = cidx_q;
    cnt_wdata   = cnt_new;
    ws_we       = 1'b0;
    ws_wdata    = mwm_pkg::FOREIGN_SLOT;
    out_load    = 1'b0;

    case (state_q)
      mwm_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          act_d       = mwm_pkg::action_e'(action_i);
          key_d       = value_i;
          res_match_d = 1'b0;
          res_start_d = '0;
          state_d     = mwm_pkg::ST_OUT;
          case (mwm_pkg::action_e'(action_i))
            mwm_pkg::ACT_CLEAR: begin
              taken_d = '0;
              used_d  = '0;
              sur_d   = '0;
              def_d   = '0;
              since_d = '0;
              pos_d   = '0;
              slot_d  = '0;
              score_d = '0;
              ovf_d   = 1'b0;
            end
            mwm_pkg::ACT_PATTERN: begin
              if (pos_q == '0 && taken_q < len_q) begin
                taken_d = taken_q + mwm_pkg::LEN_W'(1);
                scan_d  = '0;
                state_d = mwm_pkg::ST_SRCH;
              end
            end
            mwm_pkg::ACT_TEXT: begin
              if (pos_q < mwm_pkg::MAX_TEXT) begin
                state_d = mwm_pkg::ST_WS_RD;
              end
            end
            default: begin
              state_d = mwm_pkg::ST_OUT;
            end
          endcase
        end
      end

      mwm_pkg::ST_WS_RD: begin
        state_d = mwm_pkg::ST_WS_CHK;
      end

      // Retire the value that leaves the window.
      mwm_pkg::ST_WS_CHK: begin
        scan_d = '0;
        if (pos_q >= mwm_pkg::POS_W'(len_q) && !ws_rdata_q[mwm_pkg::LEN_W-1]) begin
          cidx_d  = ws_rdata_q[mwm_pkg::IDX_W-1:0];
          phase_d = mwm_pkg::PH_LEAVE;
          state_d = mwm_pkg::ST_CNT_RD;
        end else begin
          state_d = mwm_pkg::ST_SRCH;
        end
      end

      // Key scan, one entry a cycle.
      mwm_pkg::ST_SRCH: begin
        if (hit || scan_q == used_q) begin
          if (act_q == mwm_pkg::ACT_PATTERN) begin
            if (found) begin
              cidx_d  = found_idx;
              phase_d = mwm_pkg::PH_PAT;
              state_d = mwm_pkg::ST_CNT_RD;
            end else if (used_q == mwm_pkg::LEN_MAX) begin
              ovf_d   = 1'b1;
              state_d = mwm_pkg::ST_OUT;
            end else begin
              key_we    = 1'b1;
              cnt_we    = 1'b1;
              cnt_waddr = used_q[mwm_pkg::IDX_W-1:0];
              cnt_wdata = mwm_pkg::CNT_W'(1);
              used_d    = used_q + mwm_pkg::LEN_W'(1);
              sur_d     = sur_q + mwm_pkg::LEN_W'(1);
              state_d   = mwm_pkg::ST_OUT;
            end
          end else begin
            ws_we = 1'b1;
            if (found) begin
              ws_wdata = mwm_pkg::LEN_W'(found_idx);
              if (since_q != mwm_pkg::SINCE_LIMIT) begin
                since_d = since_q + mwm_pkg::POS_W'(1);
              end
              cidx_d  = found_idx;
              phase_d = mwm_pkg::PH_ENTER;
              state_d = mwm_pkg::ST_CNT_RD;
            end else begin
              since_d = '0;
              state_d = mwm_pkg::ST_FIN;
            end
          end
        end else begin
          scan_d = scan_q + mwm_pkg::LEN_W'(1);
          pend_d = 1'b1;
        end
      end

      mwm_pkg::ST_CNT_RD: begin
        state_d = mwm_pkg::ST_CNT_WR;
      end

      // Count update and surplus or deficit bookkeeping.
      mwm_pkg::ST_CNT_WR: begin
        cnt_we = 1'b1;
        if (is_up) begin
          if ($signed(cnt_new) > 0) begin
            sur_d = sur_q + mwm_pkg::LEN_W'(1);
          end else begin
            def_d = def_q - mwm_pkg::LEN_W'(1);
          end
        end else begin
          if ($signed(cnt_new) < 0) begin
            def_d = def_q + mwm_pkg::LEN_W'(1);
          end else begin
            sur_d = sur_q - mwm_pkg::LEN_W'(1);
          end
        end
        case (phase_q)
          mwm_pkg::PH_LEAVE: begin
            scan_d  = '0;
            state_d = mwm_pkg::ST_SRCH;
          end
          mwm_pkg::PH_PAT: begin
            state_d = mwm_pkg::ST_OUT;
          end
          default: begin
            state_d = mwm_pkg::ST_FIN;
          end
        endcase
      end

      // Advance the window and judge it.
      mwm_pkg::ST_FIN: begin
        pos_d = pos_inc;
        if (mwm_pkg::LEN_W'(slot_q) == len_q - mwm_pkg::LEN_W'(1)) begin
          slot_d = '0;
        end else begin
          slot_d = slot_q + mwm_pkg::IDX_W'(1);
        end
        state_d = mwm_pkg::ST_OUT;
        if (pos_inc >= mwm_pkg::POS_W'(len_q)) begin
          res_start_d = pos_inc - mwm_pkg::POS_W'(len_q) + mwm_pkg::POS_W'(1);
          if (since_q >= mwm_pkg::POS_W'(len_q) && sur_q == '0 && def_q == '0) begin
            res_match_d = 1'b1;
            state_d     = mwm_pkg::ST_SQ;
          end
        end
      end

      mwm_pkg::ST_SQ: begin
        state_d = mwm_pkg::ST_ACC;
      end

      // Saturating score accumulation.
      mwm_pkg::ST_ACC: begin
        if (acc_sum[63]) begin
          score_d = '1;
        end else begin
          score_d = acc_sum[mwm_pkg::SCORE_W-1:0];
        end
        state_d = mwm_pkg::ST_OUT;
      end

      mwm_pkg::ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = mwm_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = mwm_pkg::ST_IDLE;
      end
    endcase

    // A configuration write sets the length and clears the case.
    if (cfg_valid_i && cfg_ready_o) begin
      len_d   = cfg_len;
      taken_d = '0;
      used_d  = '0;
      sur_d   = '0;
      def_d   = '0;
      since_d = '0;
      pos_d   = '0;
      slot_d  = '0;
      score_d = '0;
      ovf_d   = 1'b0;
    end
  end

  // Output valid holds until the transfer completes.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign in_stall_o       = (state_q != mwm_pkg::ST_IDLE);
  assign cfg_ready_o      = (state_q == mwm_pkg::ST_IDLE) && !in_valid_i;
  assign out_valid_o      = out_valid_q;
  assign window_match_o   = out_match_q;
  assign window_start_o   = out_start_q;
  assign score_total_o    = out_score_q;
  assign table_overflow_o = out_ovf_q;

endmodule

// ===== sv/mwm_checker.sv =====
module mwm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        window_match_o,
  input logic [16:0] window_start_o,
  input logic [62:0] score_total_o
);

  // A stalled result stays offered with the same score.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(score_total_o))
    else $error("stalled result changed");

  // A match always names a full window.
  a_match_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && window_match_o |-> window_start_o != 17'd0)
    else $error("match without window start");

  // The block is busy in the cycle after it takes an item.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transfer without processing");

  // While no result is offered, taking an item does not offer one straight away.
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared too early");

endmodule

bind multiset_window_match mwm_checker u_mwm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .window_match_o (window_match_o),
  .window_start_o (window_start_o),
  .score_total_o  (score_total_o)
);
